@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every rising clock edge outside reset.
`define AST_HOLD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check that a condition never occurs outside reset.
`define AST_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`else

`define AST_HOLD(lbl, clk, rstn, prop, msg)
`define AST_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ hw/rtl/fame_pkg.sv @@
// ----------------------------------------------------------------------------
// fame_pkg
// Shared widths, item codes and types of the arc match epsilon filter.
// ----------------------------------------------------------------------------
package fame_pkg;

    localparam int LABEL_W   = 16;
    localparam int PAYLOAD_W = 32;
    localparam int INDEX_W   = 5;
    localparam int KIND_W    = 2;
    localparam int FSTATE_W  = 2;
    localparam int ENTRY_W   = 2 * LABEL_W + PAYLOAD_W;

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd2;

    // Configuration register indexes
    localparam logic REG_EPSILON = 1'b0;
    localparam logic REG_LOOP    = 1'b1;

    typedef logic [LABEL_W-1:0] label_t;

    // Verdict of the composition filter for one arc pair
    typedef struct packed {
        logic admit;
        logic next_f;
    } filt_res_t;

endpackage

@@ hw/rtl/fame_ram.sv @@
// ----------------------------------------------------------------------------
// fame_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fame_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fame_filter.sv @@
// ----------------------------------------------------------------------------
// fame_filter
// Composition epsilon filter: decides whether a probe output label and a
// stored input label pair up, and gives the new filter state.
// ----------------------------------------------------------------------------
module fame_filter (
    input  fame_pkg::label_t    probe_ol,
    input  fame_pkg::label_t    stored_il,
    input  fame_pkg::label_t    eps_label,
    input  fame_pkg::label_t    loop_label,
    input  logic                fstate_zero,
    output fame_pkg::filt_res_t res
);
    import fame_pkg::*;

    logic same;
    logic ol_eps;
    logic ol_loop;
    logic il_eps;
    logic il_loop;

    assign same    = (probe_ol == stored_il);
    assign ol_eps  = (probe_ol == eps_label);
    assign ol_loop = (probe_ol == loop_label);
    assign il_eps  = (stored_il == eps_label);
    assign il_loop = (stored_il == loop_label);

    // Try the rules in priority order
    always_comb begin
        res.admit  = 1'b0;
        res.next_f = 1'b0;
        if (same && !ol_eps && !ol_loop) begin
            res.admit = 1'b1;
        end else if (ol_eps && il_loop && fstate_zero) begin
            res.admit = 1'b1;
        end else if (ol_loop && il_eps) begin
            res.admit  = 1'b1;
            res.next_f = 1'b1;
        end
    end

endmodule

@@ hw/rtl/fst_arc_match_epsilon_filter.sv @@
// ----------------------------------------------------------------------------
// fst_arc_match_epsilon_filter
// Arc matcher for transducer composition with an epsilon filter.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) takes one word per item: clear the arc table,
//   append one arc, or probe the table with an arc and a filter state.
//   The result channel (m_*) returns, for each probe, every stored arc whose
//   input label pairs with the probe's output label, in index order, with
//   last_flag on the final word; a probe without a match returns one word
//   with match_flag clear. Clear and append return nothing. The user must set
//   epsilon codes on the cfg_* write port only while idle; not enforced here.
// Operation:
//   Clear and append complete without leaving the idle state. A probe scans
//   the table, reading one entry from the RAM and then running it through
//   the shared filter compare, entry by entry. s_ready is low for the
//   whole probe.
//   A stalled receiver holds the output register; the scan waits on the next
//   match until the word ahead of it is taken.
// Reset: the table count and all control state clear; table contents are
//   undefined until appended; epsilon is 0 and the loop marker 65535.
// ----------------------------------------------------------------------------
module fst_arc_match_epsilon_filter #(
    parameter int MAX_ARCS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [fame_pkg::LABEL_W-1:0]        cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fame_pkg::KIND_W-1:0]         s_kind,
    input  logic [fame_pkg::LABEL_W-1:0]        s_arc_ilabel,
    input  logic [fame_pkg::LABEL_W-1:0]        s_arc_olabel,
    input  logic [fame_pkg::PAYLOAD_W-1:0]      s_arc_payload,
    input  logic [fame_pkg::FSTATE_W-1:0]       s_filter_state,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fame_pkg::LABEL_W-1:0]        m_probe_ilabel,
    output logic [fame_pkg::LABEL_W-1:0]        m_probe_olabel,
    output logic [fame_pkg::PAYLOAD_W-1:0]      m_probe_payload,
    output logic [fame_pkg::INDEX_W-1:0]        m_stored_index,
    output logic [fame_pkg::LABEL_W-1:0]        m_stored_ilabel,
    output logic [fame_pkg::LABEL_W-1:0]        m_stored_olabel,
    output logic [fame_pkg::PAYLOAD_W-1:0]      m_stored_payload,
    output logic                                m_next_filter,
    output logic                                m_match_flag,
    output logic                                m_last_flag
);
    import fame_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int CNT_W = $clog2(MAX_ARCS + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hold_valid_reg, hold_valid_next;
    logic             m_valid_reg, m_valid_next;
    label_t           eps_reg, eps_next;
    label_t           loop_reg, loop_next;

    // Probe arc
    label_t                pr_il_reg, pr_il_next;
    label_t                pr_ol_reg, pr_ol_next;
    logic [PAYLOAD_W-1:0]  pr_pl_reg, pr_pl_next;
    logic                  pr_fzero_reg, pr_fzero_next;

    // Pending match, sent once the next match or the scan end shows up
    logic [IDX_W-1:0]      hold_idx_reg, hold_idx_next;
    label_t                hold_il_reg, hold_il_next;
    label_t                hold_ol_reg, hold_ol_next;
    logic [PAYLOAD_W-1:0]  hold_pl_reg, hold_pl_next;
    logic                  hold_nf_reg, hold_nf_next;

    // Output register payload
    label_t                o_pil_reg, o_pil_next;
    label_t                o_pol_reg, o_pol_next;
    logic [PAYLOAD_W-1:0]  o_ppl_reg, o_ppl_next;
    logic [INDEX_W-1:0]    o_idx_reg, o_idx_next;
    label_t                o_sil_reg, o_sil_next;
    label_t                o_sol_reg, o_sol_next;
    logic [PAYLOAD_W-1:0]  o_spl_reg, o_spl_next;
    logic                  o_nf_reg, o_nf_next;
    logic                  o_match_reg, o_match_next;
    logic                  o_last_reg, o_last_next;

    // Table RAM and filter
    logic                  ram_we;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    label_t                rd_il;
    label_t                rd_ol;
    logic [PAYLOAD_W-1:0]  rd_pl;
    filt_res_t             filt;

    logic                  accept;
    logic                  out_free;
    logic                  scan_end;
    logic [CNT_W:0]        idx_plus1;

    fame_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ARCS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {s_arc_ilabel, s_arc_olabel, s_arc_payload};
    assign rd_il     = ram_rdata[ENTRY_W-1 -: LABEL_W];
    assign rd_ol     = ram_rdata[PAYLOAD_W +: LABEL_W];
    assign rd_pl     = ram_rdata[PAYLOAD_W-1:0];

    fame_filter u_filter (
        .probe_ol    (pr_ol_reg),
        .stored_il   (rd_il),
        .eps_label   (eps_reg),
        .loop_label  (loop_reg),
        .fstate_zero (pr_fzero_reg),
        .res         (filt)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign idx_plus1 = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1);
    assign scan_end  = (idx_plus1 == {1'b0, count_reg});

    // Sequencer and datapath next state
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        eps_next        = eps_reg;
        loop_next       = loop_reg;
        pr_il_next      = pr_il_reg;
        pr_ol_next      = pr_ol_reg;
        pr_pl_next      = pr_pl_reg;
        pr_fzero_next   = pr_fzero_reg;
        hold_idx_next   = hold_idx_reg;
        hold_il_next    = hold_il_reg;
        hold_ol_next    = hold_ol_reg;
        hold_pl_next    = hold_pl_reg;
        hold_nf_next    = hold_nf_reg;
        o_pil_next      = o_pil_reg;
        o_pol_next      = o_pol_reg;
        o_ppl_next      = o_ppl_reg;
        o_idx_next      = o_idx_reg;
        o_sil_next      = o_sil_reg;
        o_sol_next      = o_sol_reg;
        o_spl_next      = o_spl_reg;
        o_nf_next       = o_nf_reg;
        o_match_next    = o_match_reg;
        o_last_next     = o_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        // Configuration writes
        if (cfg_we) begin
            case (cfg_index)
                REG_EPSILON: eps_next  = cfg_wdata;
                REG_LOOP:    loop_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_CLEAR: begin
                            count_next = '0;
                        end
                        KIND_APPEND: begin
                            // Drop appends once the table is full
                            if (count_reg < CNT_W'(MAX_ARCS)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_PROBE: begin
                            pr_il_next      = s_arc_ilabel;
                            pr_ol_next      = s_arc_olabel;
                            pr_pl_next      = s_arc_payload;
                            pr_fzero_next   = (s_filter_state == '0);
                            idx_next        = '0;
                            hold_valid_next = 1'b0;
                            state_next      = (count_reg == '0) ? ST_FLUSH : ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // Advance unless a held match must go out and the output is busy
                if (!filt.admit || !hold_valid_reg || out_free) begin
                    if (filt.admit) begin
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            o_pil_next   = pr_il_reg;
                            o_pol_next   = pr_ol_reg;
                            o_ppl_next   = pr_pl_reg;
                            o_idx_next   = INDEX_W'(hold_idx_reg);
                            o_sil_next   = hold_il_reg;
                            o_sol_next   = hold_ol_reg;
                            o_spl_next   = hold_pl_reg;
                            o_nf_next    = hold_nf_reg;
                            o_match_next = 1'b1;
                            o_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_idx_next   = idx_reg;
                        hold_il_next    = rd_il;
                        hold_ol_next    = rd_ol;
                        hold_pl_next    = rd_pl;
                        hold_nf_next    = filt.next_f;
                    end
                    if (scan_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                // Send the final word: the held match or a no-match word
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    o_pil_next      = pr_il_reg;
                    o_pol_next      = pr_ol_reg;
                    o_ppl_next      = pr_pl_reg;
                    o_last_next     = 1'b1;
                    o_match_next    = hold_valid_reg;
                    if (hold_valid_reg) begin
                        o_idx_next = INDEX_W'(hold_idx_reg);
                        o_sil_next = hold_il_reg;
                        o_sol_next = hold_ol_reg;
                        o_spl_next = hold_pl_reg;
                        o_nf_next  = hold_nf_reg;
                    end else begin
                        o_idx_next = '0;
                        o_sil_next = '0;
                        o_sol_next = '0;
                        o_spl_next = '0;
                        o_nf_next  = 1'b0;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            eps_reg        <= '0;
            loop_reg       <= '1;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            eps_reg        <= eps_next;
            loop_reg       <= loop_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pr_il_reg    <= pr_il_next;
        pr_ol_reg    <= pr_ol_next;
        pr_pl_reg    <= pr_pl_next;
        pr_fzero_reg <= pr_fzero_next;
        hold_idx_reg <= hold_idx_next;
        hold_il_reg  <= hold_il_next;
        hold_ol_reg  <= hold_ol_next;
        hold_pl_reg  <= hold_pl_next;
        hold_nf_reg  <= hold_nf_next;
        o_pil_reg    <= o_pil_next;
        o_pol_reg    <= o_pol_next;
        o_ppl_reg    <= o_ppl_next;
        o_idx_reg    <= o_idx_next;
        o_sil_reg    <= o_sil_next;
        o_sol_reg    <= o_sol_next;
        o_spl_reg    <= o_spl_next;
        o_nf_reg     <= o_nf_next;
        o_match_reg  <= o_match_next;
        o_last_reg   <= o_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_probe_ilabel   = o_pil_reg;
    assign m_probe_olabel   = o_pol_reg;
    assign m_probe_payload  = o_ppl_reg;
    assign m_stored_index   = o_idx_reg;
    assign m_stored_ilabel  = o_sil_reg;
    assign m_stored_olabel  = o_sol_reg;
    assign m_stored_payload = o_spl_reg;
    assign m_next_filter    = o_nf_reg;
    assign m_match_flag     = o_match_reg;
    assign m_last_flag      = o_last_reg;

    // Checks
    `AST_HOLD(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_ARCS), "table count overflow")
    `AST_HOLD(a_nomatch_last, aclk, aresetn, (m_valid && !m_match_flag) |-> m_last_flag, "no-match word without last")
    `AST_NEVER(a_scan_empty, aclk, aresetn, (state_reg == ST_READ) && (count_reg == '0), "scan of empty table")
    `AST_NEVER(a_hold_ready, aclk, aresetn, hold_valid_reg && s_ready, "input taken with match pending")

endmodule
